@@ src/tkf_pkg.sv @@
// Package for the three-axis Kalman filter core: fixed-point widths, reset
// values, item kinds, register indexes and the estimate saturation helper.
// No dependencies.
package tkf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int GAIN_BITS = 16;

    localparam int DATA_W = 32;
    localparam int VAR_W  = 32;
    localparam int NUM_CH = 3;
    localparam int CH_W   = 2;
    localparam int ADDR_W = 5;
    localparam int IDX_W  = 3;

    localparam int GAIN_W  = GAIN_BITS + 1;
    localparam int CNT_W   = $clog2(GAIN_BITS + 1);
    localparam int DEN_W   = VAR_W + 1;
    localparam int MUL_A_W = DATA_W + 2;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DELTA_W = PROD_W - GAIN_BITS;

    typedef logic signed [DATA_W-1:0] est_t;
    typedef logic [VAR_W-1:0]         var_t;
    typedef logic [GAIN_W-1:0]        gain_t;

    localparam logic [CH_W-1:0] CH_X    = 2'd0;
    localparam logic [CH_W-1:0] CH_Y    = 2'd1;
    localparam logic [CH_W-1:0] CH_HEAD = 2'd2;

    localparam logic [1:0] KIND_INIT    = 2'd0;
    localparam logic [1:0] KIND_PREDICT = 2'd1;
    localparam logic [1:0] KIND_UPDATE  = 2'd2;

    localparam logic [IDX_W-1:0] REG_PROC_NOISE_POS  = 3'd0;
    localparam logic [IDX_W-1:0] REG_PROC_NOISE_HEAD = 3'd1;
    localparam logic [IDX_W-1:0] REG_MEAS_NOISE_POS  = 3'd2;
    localparam logic [IDX_W-1:0] REG_MEAS_NOISE_HEAD = 3'd3;
    localparam logic [IDX_W-1:0] REG_INIT_VAR_POS    = 3'd4;
    localparam logic [IDX_W-1:0] REG_INIT_VAR_HEAD   = 3'd5;

    localparam longint unsigned ONE_FX = 64'd1 << FRAC_BITS;

    localparam var_t PROC_NOISE_POS_RST  = VAR_W'((ONE_FX + 64'd10) / 64'd20);
    localparam var_t PROC_NOISE_HEAD_RST = VAR_W'(2 * ONE_FX);
    localparam var_t MEAS_NOISE_POS_RST  = VAR_W'(ONE_FX / 64'd2);
    localparam var_t MEAS_NOISE_HEAD_RST = VAR_W'(15 * ONE_FX);
    localparam var_t INIT_VAR_POS_RST    = VAR_W'((ONE_FX + 64'd5) / 64'd10);
    localparam var_t INIT_VAR_HEAD_RST   = VAR_W'(5 * ONE_FX);

    localparam gain_t ONE_GAIN = {1'b1, {GAIN_BITS{1'b0}}};

    localparam logic signed [PROD_W-1:0] ROUND_BIAS =
        PROD_W'(64'sd1 <<< (GAIN_BITS - 1));

    localparam longint EST_MAX_L = (64'sd1 <<< (DATA_W - 1)) - 64'sd1;
    localparam longint EST_MIN_L = -(64'sd1 <<< (DATA_W - 1));
    localparam logic signed [DELTA_W:0] EST_MAX_X = (DELTA_W + 1)'(EST_MAX_L);
    localparam logic signed [DELTA_W:0] EST_MIN_X = (DELTA_W + 1)'(EST_MIN_L);

    function automatic est_t sat_est(input logic signed [DELTA_W:0] v);
        est_t r;
        if (v > EST_MAX_X)
            r = EST_MAX_X[DATA_W-1:0];
        else if (v < EST_MIN_X)
            r = EST_MIN_X[DATA_W-1:0];
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

@@ src/three_axis_kalman_filter_core.sv @@
// Three-axis (x, y, heading) scalar Kalman filter core with APB register port.
// Depends on tkf_pkg.
//
// One item at a time. Init, predict and unknown kinds pass through S_EXEC and
// S_OUT, which loads the result into the output register, and then return to
// S_IDLE for the next transfer. An update runs the three channels one after another
// through a shared restoring divider (one quotient bit per cycle) and a shared
// 34x18 multiplier (innovation term, then variance term); each channel passes
// S_DIV_INIT, S_DIV, S_MUL_GAIN, S_MUL_VAR and S_VAR, and S_DIV is skipped when
// p + r is zero. The result is held in an output register, so a stalled output
// only holds the next item in S_OUT.
module three_axis_kalman_filter_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tkf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [1:0]                kind,
    input  logic signed [31:0]        val_x,
    input  logic signed [31:0]        val_y,
    input  logic signed [31:0]        val_heading,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [31:0]        est_x,
    output logic signed [31:0]        est_y,
    output logic signed [31:0]        est_heading
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EXEC     = 4'd1;
    localparam logic [3:0] S_DIV_INIT = 4'd2;
    localparam logic [3:0] S_DIV      = 4'd3;
    localparam logic [3:0] S_MUL_GAIN = 4'd4;
    localparam logic [3:0] S_MUL_VAR  = 4'd5;
    localparam logic [3:0] S_VAR      = 4'd6;
    localparam logic [3:0] S_OUT      = 4'd7;

    // configuration
    tkf_pkg::var_t proc_noise_pos_reg, proc_noise_head_reg;
    tkf_pkg::var_t meas_noise_pos_reg, meas_noise_head_reg;
    tkf_pkg::var_t init_var_pos_reg, init_var_head_reg;

    // control
    logic [3:0]               state_reg, state_next;
    logic [tkf_pkg::CH_W-1:0] ch_reg, ch_next;
    logic [tkf_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                     out_valid_reg, out_valid_next;

    // filter state
    tkf_pkg::est_t est_reg [tkf_pkg::NUM_CH];
    tkf_pkg::est_t est_next [tkf_pkg::NUM_CH];
    tkf_pkg::est_t pest_reg [tkf_pkg::NUM_CH];
    tkf_pkg::est_t pest_next [tkf_pkg::NUM_CH];
    tkf_pkg::var_t var_reg [tkf_pkg::NUM_CH];
    tkf_pkg::var_t var_next [tkf_pkg::NUM_CH];
    tkf_pkg::var_t pvar_reg [tkf_pkg::NUM_CH];
    tkf_pkg::var_t pvar_next [tkf_pkg::NUM_CH];

    // datapath
    logic [1:0]    kind_reg, kind_next;
    tkf_pkg::est_t val_reg [tkf_pkg::NUM_CH];
    tkf_pkg::est_t val_next [tkf_pkg::NUM_CH];
    logic [tkf_pkg::DEN_W-1:0] den_reg, den_next;
    logic [tkf_pkg::DEN_W-1:0] rem_reg, rem_next;
    tkf_pkg::gain_t quo_reg, quo_next;
    logic signed [tkf_pkg::PROD_W-1:0] prod_reg, prod_next;
    tkf_pkg::est_t out_x_reg, out_x_next;
    tkf_pkg::est_t out_y_reg, out_y_next;
    tkf_pkg::est_t out_h_reg, out_h_next;

    logic signed [tkf_pkg::MUL_A_W-1:0] mul_a;
    logic signed [tkf_pkg::MUL_B_W-1:0] mul_b;
    logic signed [tkf_pkg::PROD_W-1:0]  mul_p;

    logic cfg_wr;
    logic [tkf_pkg::IDX_W-1:0] cfg_idx;

    tkf_pkg::var_t r_sel;
    tkf_pkg::var_t pvar_sel;
    tkf_pkg::est_t pest_sel, val_sel;
    logic signed [tkf_pkg::DATA_W:0] innov;
    logic [tkf_pkg::DEN_W+1:0] trial;
    logic nbit;
    logic signed [tkf_pkg::PROD_W-1:0] prod_rnd;
    logic signed [tkf_pkg::DELTA_W-1:0] delta;
    logic signed [tkf_pkg::DELTA_W:0] est_sum;
    tkf_pkg::var_t var_new;
    logic [tkf_pkg::VAR_W:0] pred_sum [tkf_pkg::NUM_CH];

    // APB
    assign pready  = 1'b1;
    assign cfg_idx = paddr[tkf_pkg::ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (cfg_idx)
            tkf_pkg::REG_PROC_NOISE_POS:  prdata = proc_noise_pos_reg;
            tkf_pkg::REG_PROC_NOISE_HEAD: prdata = proc_noise_head_reg;
            tkf_pkg::REG_MEAS_NOISE_POS:  prdata = meas_noise_pos_reg;
            tkf_pkg::REG_MEAS_NOISE_HEAD: prdata = meas_noise_head_reg;
            tkf_pkg::REG_INIT_VAR_POS:    prdata = init_var_pos_reg;
            tkf_pkg::REG_INIT_VAR_HEAD:   prdata = init_var_head_reg;
            default:                      prdata = '0;
        endcase
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign est_x       = out_x_reg;
    assign est_y       = out_y_reg;
    assign est_heading = out_h_reg;

    // per-channel selection
    assign r_sel  = (ch_reg == tkf_pkg::CH_HEAD) ? meas_noise_head_reg : meas_noise_pos_reg;
    assign pvar_sel = pvar_reg[ch_reg];
    assign pest_sel = pest_reg[ch_reg];
    assign val_sel  = val_reg[ch_reg];

    assign innov = (tkf_pkg::DATA_W + 1)'(val_sel) - (tkf_pkg::DATA_W + 1)'(pest_sel);

    // restoring divide step; the first step brings in bit 0 of p
    assign nbit  = (cnt_reg == tkf_pkg::CNT_W'(tkf_pkg::GAIN_BITS)) ? pvar_sel[0] : 1'b0;
    assign trial = {1'b0, rem_reg, nbit} - {2'b00, den_reg};

    // shared multiplier: innovation times gain, then p times (1 - gain)
    assign mul_a = (state_reg == S_MUL_VAR) ? {2'b00, pvar_sel} : tkf_pkg::MUL_A_W'(innov);
    assign mul_b = (state_reg == S_MUL_VAR) ? {1'b0, tkf_pkg::ONE_GAIN - quo_reg}
                                            : {1'b0, quo_reg};
    assign mul_p = mul_a * mul_b;

    assign prod_rnd = prod_reg + tkf_pkg::ROUND_BIAS;
    assign delta    = prod_rnd[tkf_pkg::PROD_W-1:tkf_pkg::GAIN_BITS];
    assign est_sum  = (tkf_pkg::DELTA_W + 1)'(pest_sel) + (tkf_pkg::DELTA_W + 1)'(delta);
    assign var_new  = prod_rnd[tkf_pkg::GAIN_BITS +: tkf_pkg::VAR_W];

    always_comb
    begin
        for (int i = 0; i < tkf_pkg::NUM_CH; i++)
        begin
            pred_sum[i] = {1'b0, var_reg[i]}
                        + {1'b0, (i == int'(tkf_pkg::CH_HEAD)) ? proc_noise_head_reg
                                                                : proc_noise_pos_reg};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        prod_next      = prod_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_h_next     = out_h_reg;
        for (int i = 0; i < tkf_pkg::NUM_CH; i++)
        begin
            est_next[i]  = est_reg[i];
            pest_next[i] = pest_reg[i];
            var_next[i]  = var_reg[i];
            pvar_next[i] = pvar_reg[i];
            val_next[i]  = val_reg[i];
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next   = kind;
                    val_next[0] = val_x;
                    val_next[1] = val_y;
                    val_next[2] = val_heading;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ch_next    = tkf_pkg::CH_X;
                state_next = S_OUT;
                case (kind_reg)
                    tkf_pkg::KIND_INIT:
                    begin
                        for (int i = 0; i < tkf_pkg::NUM_CH; i++)
                        begin
                            est_next[i]  = val_reg[i];
                            var_next[i]  = (i == int'(tkf_pkg::CH_HEAD)) ? init_var_head_reg
                                                                        : init_var_pos_reg;
                            pvar_next[i] = '0;
                        end
                    end
                    tkf_pkg::KIND_PREDICT:
                    begin
                        for (int i = 0; i < tkf_pkg::NUM_CH; i++)
                        begin
                            pest_next[i] = est_reg[i];
                            pvar_next[i] = pred_sum[i][tkf_pkg::VAR_W] ? '1
                                         : pred_sum[i][tkf_pkg::VAR_W-1:0];
                        end
                    end
                    tkf_pkg::KIND_UPDATE:
                        state_next = S_DIV_INIT;
                    default: ;
                endcase
            end
            S_DIV_INIT:
            begin
                den_next = {1'b0, pvar_sel} + {1'b0, r_sel};
                quo_next = '0;
                rem_next = {2'b00, pvar_sel[tkf_pkg::VAR_W-1:1]};
                cnt_next = tkf_pkg::CNT_W'(tkf_pkg::GAIN_BITS);
                // zero sum: gain stays zero
                if (pvar_sel == '0 && r_sel == '0)
                    state_next = S_MUL_GAIN;
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!trial[tkf_pkg::DEN_W+1])
                begin
                    rem_next = trial[tkf_pkg::DEN_W-1:0];
                    quo_next = {quo_reg[tkf_pkg::GAIN_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[tkf_pkg::DEN_W-2:0], nbit};
                    quo_next = {quo_reg[tkf_pkg::GAIN_W-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                    state_next = S_MUL_GAIN;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_MUL_GAIN:
            begin
                prod_next  = mul_p;
                state_next = S_MUL_VAR;
            end
            S_MUL_VAR:
            begin
                est_next[ch_reg]  = tkf_pkg::sat_est(est_sum);
                pest_next[ch_reg] = tkf_pkg::sat_est(est_sum);
                prod_next  = mul_p;
                state_next = S_VAR;
            end
            S_VAR:
            begin
                var_next[ch_reg] = var_new;
                if (ch_reg == tkf_pkg::CH_HEAD)
                    state_next = S_OUT;
                else
                begin
                    ch_next    = ch_reg + 1'b1;
                    state_next = S_DIV_INIT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_x_next     = est_reg[0];
                    out_y_next     = est_reg[1];
                    out_h_next     = est_reg[2];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            ch_reg              <= tkf_pkg::CH_X;
            cnt_reg             <= '0;
            out_valid_reg       <= 1'b0;
            proc_noise_pos_reg  <= tkf_pkg::PROC_NOISE_POS_RST;
            proc_noise_head_reg <= tkf_pkg::PROC_NOISE_HEAD_RST;
            meas_noise_pos_reg  <= tkf_pkg::MEAS_NOISE_POS_RST;
            meas_noise_head_reg <= tkf_pkg::MEAS_NOISE_HEAD_RST;
            init_var_pos_reg    <= tkf_pkg::INIT_VAR_POS_RST;
            init_var_head_reg   <= tkf_pkg::INIT_VAR_HEAD_RST;
            for (int i = 0; i < tkf_pkg::NUM_CH; i++)
            begin
                est_reg[i]  <= '0;
                pest_reg[i] <= '0;
                pvar_reg[i] <= '0;
                var_reg[i]  <= (i == int'(tkf_pkg::CH_HEAD)) ? tkf_pkg::INIT_VAR_HEAD_RST
                                                            : tkf_pkg::INIT_VAR_POS_RST;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < tkf_pkg::NUM_CH; i++)
            begin
                est_reg[i]  <= est_next[i];
                pest_reg[i] <= pest_next[i];
                var_reg[i]  <= var_next[i];
                pvar_reg[i] <= pvar_next[i];
            end
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    tkf_pkg::REG_PROC_NOISE_POS:  proc_noise_pos_reg  <= pwdata;
                    tkf_pkg::REG_PROC_NOISE_HEAD: proc_noise_head_reg <= pwdata;
                    tkf_pkg::REG_MEAS_NOISE_POS:  meas_noise_pos_reg  <= pwdata;
                    tkf_pkg::REG_MEAS_NOISE_HEAD: meas_noise_head_reg <= pwdata;
                    tkf_pkg::REG_INIT_VAR_POS:    init_var_pos_reg    <= pwdata;
                    tkf_pkg::REG_INIT_VAR_HEAD:   init_var_head_reg   <= pwdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        prod_reg  <= prod_next;
        out_x_reg <= out_x_next;
        out_y_reg <= out_y_next;
        out_h_reg <= out_h_next;
        for (int i = 0; i < tkf_pkg::NUM_CH; i++)
            val_reg[i] <= val_next[i];
    end

    // checks
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_EXEC)
        else $error("accepted transfer did not start execution");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL_GAIN |-> quo_reg <= tkf_pkg::ONE_GAIN)
        else $error("gain above one");

    a_var_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_VAR |-> var_new <= pvar_sel)
        else $error("updated variance exceeds predicted variance");

    a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> ch_reg <= tkf_pkg::CH_HEAD)
        else $error("channel index out of range");

endmodule

@@ bench/three_axis_kalman_filter_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for three_axis_kalman_filter_core: directed table, then random init,
// predict, update and unknown items over several noise settings, checked by a local predictor.
// Depends on tkf_pkg and three_axis_kalman_filter_core.
module three_axis_kalman_filter_core_test;
    import tkf_pkg::*;

    localparam int NUM_REGS = 6;
    localparam int DIR_ROWS = 20;
    localparam int N_PHASES = 8;
    localparam int PHASE_ITEMS = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam longint unsigned VAR_MAX = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vh;
    } item_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] h;
    } est_set_t;

    typedef struct packed {
        item_t    stim;
        logic     known;
        est_set_t want;
    } dir_row_t;

    // typed expectations only where the estimate is plain from the stimulus
    localparam dir_row_t DIR_TBL [DIR_ROWS] = '{
        '{'{KIND_NONE, 32'h0001_2345, 32'hFEDC_BA98, 32'h7FFF_0000}, 1'b1,
          '{32'h0, 32'h0, 32'h0}},
        '{'{KIND_PREDICT, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 1'b1,
          '{32'h0, 32'h0, 32'h0}},
        '{'{KIND_UPDATE, 32'h0001_0000, 32'hFFFF_0000, 32'h0005_0000}, 1'b0, '0},
        '{'{KIND_INIT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000}, 1'b1,
          '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000}},
        '{'{KIND_NONE, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003}, 1'b1,
          '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000}},
        '{'{KIND_PREDICT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1,
          '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000}},
        '{'{KIND_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, '0},
        '{'{KIND_INIT, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
          '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF}},
        '{'{KIND_PREDICT, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000}, 1'b1,
          '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF}},
        '{'{KIND_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000}, 1'b0, '0},
        '{'{KIND_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000}, 1'b0, '0},
        '{'{KIND_INIT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1,
          '{32'h0, 32'h0, 32'h0}},
        '{'{KIND_PREDICT, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF}, 1'b1,
          '{32'h0, 32'h0, 32'h0}},
        '{'{KIND_PREDICT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b1,
          '{32'h0, 32'h0, 32'h0}},
        '{'{KIND_UPDATE, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000}, 1'b0, '0},
        '{'{KIND_UPDATE, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000}, 1'b0, '0},
        '{'{KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
        '{'{KIND_INIT, 32'hFFFF_FFFF, 32'h0000_0001, 32'h1234_5678}, 1'b1,
          '{32'hFFFF_FFFF, 32'h0000_0001, 32'h1234_5678}},
        '{'{KIND_UPDATE, 32'h0100_0000, 32'hFF00_0000, 32'h0000_0000}, 1'b0, '0},
        '{'{KIND_PREDICT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic in_valid;
    logic in_ready;
    logic [1:0] kind;
    logic signed [31:0] val_x;
    logic signed [31:0] val_y;
    logic signed [31:0] val_heading;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic signed [31:0] est_heading;

    // filter state mirrored from the block
    var_t cfg_regs [NUM_REGS];
    longint est_q [NUM_CH];
    longint pest_q [NUM_CH];
    longint unsigned var_q [NUM_CH];
    longint unsigned pvar_q [NUM_CH];

    est_set_t estimates_due [$];
    est_set_t seen;
    est_set_t want;
    string field_name [NUM_CH] = '{"est_x", "est_y", "est_heading"};
    int mismatches = 0;
    int idle_cycles = 0;
    int stall_left = 0;
    bit quiet = 1'b0;
    bit upd_next = 1'b0;

    three_axis_kalman_filter_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .val_x       (val_x),
        .val_y       (val_y),
        .val_heading (val_heading),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .est_x       (est_x),
        .est_y       (est_y),
        .est_heading (est_heading)
    );

    always #10 clk = ~clk;

    function automatic est_set_t filter_step(input item_t it);
        int ch;
        longint val;
        longint innov;
        longint delta;
        longint upd;
        longint unsigned p;
        longint unsigned s;
        longint unsigned k;
        longint unsigned nv;
        longint unsigned q;
        longint unsigned r;
        est_set_t res;
        for (ch = 0; ch < NUM_CH; ch++)
        begin
            val = (ch == CH_X) ? $signed(it.vx) : (ch == CH_Y) ? $signed(it.vy) : $signed(it.vh);
            q = (ch == CH_HEAD) ? cfg_regs[REG_PROC_NOISE_HEAD] : cfg_regs[REG_PROC_NOISE_POS];
            r = (ch == CH_HEAD) ? cfg_regs[REG_MEAS_NOISE_HEAD] : cfg_regs[REG_MEAS_NOISE_POS];
            case (it.kind)
                KIND_INIT:
                begin
                    est_q[ch] = val;
                    var_q[ch] = (ch == CH_HEAD) ? cfg_regs[REG_INIT_VAR_HEAD]
                                                : cfg_regs[REG_INIT_VAR_POS];
                    pvar_q[ch] = 0;
                end
                KIND_PREDICT:
                begin
                    s = var_q[ch] + q;
                    pest_q[ch] = est_q[ch];
                    pvar_q[ch] = (s > VAR_MAX) ? VAR_MAX : s;
                end
                KIND_UPDATE:
                begin
                    p = pvar_q[ch];
                    s = p + r;
                    k = (s != 0) ? (p << GAIN_BITS) / s : 64'd0;
                    innov = val - pest_q[ch];
                    delta = (innov * longint'(k) + (64'sd1 <<< (GAIN_BITS - 1))) >>> GAIN_BITS;
                    upd = pest_q[ch] + delta;
                    if (upd > EST_MAX_L)
                        upd = EST_MAX_L;
                    else if (upd < EST_MIN_L)
                        upd = EST_MIN_L;
                    nv = (((64'd1 << GAIN_BITS) - k) * p + (64'd1 << (GAIN_BITS - 1)))
                         >> GAIN_BITS;
                    est_q[ch] = upd;
                    pest_q[ch] = upd;
                    var_q[ch] = (nv > VAR_MAX) ? VAR_MAX : nv;
                end
                default: ;
            endcase
        end
        res.x = 32'(est_q[CH_X]);
        res.y = 32'(est_q[CH_Y]);
        res.h = 32'(est_q[CH_HEAD]);
        return res;
    endfunction

    // measurements mostly near the prediction so the gain has something to pull
    function automatic logic [31:0] pick_value(input longint centre);
        longint offset;
        offset = longint'($urandom_range(0, 2097152)) - 64'sd1048576;
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return 32'(centre + offset);
        endcase
    endfunction

    function automatic item_t next_item();
        item_t it;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            it.kind = KIND_INIT;
        else if (roll < 10)
            it.kind = KIND_NONE;
        else if (roll < 14)
            it.kind = 2'($urandom_range(0, 3));
        else
        begin
            it.kind = upd_next ? KIND_UPDATE : KIND_PREDICT;
            upd_next = !upd_next;
        end
        it.vx = pick_value(pest_q[CH_X]);
        it.vy = pick_value(pest_q[CH_Y]);
        it.vh = pick_value(pest_q[CH_HEAD]);
        return it;
    endfunction

    task automatic send(input item_t it, input logic known, input est_set_t typed_est);
        int gap;
        est_set_t model_est;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= it.kind;
        val_x <= it.vx;
        val_y <= it.vy;
        val_heading <= it.vh;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        model_est = filter_step(it);
        estimates_due.push_back(known ? typed_est : model_est);
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            send(next_item(), 1'b0, '0);
        end
        in_valid <= 1'b0;
    endtask

    task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx < NUM_REGS)
            cfg_regs[idx] = data;
    endtask

    task automatic apb_read_check(input logic [IDX_W-1:0] idx);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== cfg_regs[idx])
        begin
            mismatches++;
            $display("%0t: register %0d expected %h got %h", $time, idx, cfg_regs[idx], prdata);
        end
    endtask

    task automatic configure(input var_t qp, input var_t qh, input var_t rp, input var_t rh,
                             input var_t pp, input var_t ph);
        while (estimates_due.size() != 0)
            @(posedge clk);
        apb_write(REG_PROC_NOISE_POS, qp);
        apb_write(REG_PROC_NOISE_HEAD, qh);
        apb_write(REG_MEAS_NOISE_POS, rp);
        apb_write(REG_MEAS_NOISE_HEAD, rh);
        apb_write(REG_INIT_VAR_POS, pp);
        apb_write(REG_INIT_VAR_HEAD, ph);
        // unmapped addresses must not alias onto real registers
        apb_write(REG_SPARE_LO, $urandom);
        apb_write(REG_SPARE_HI, $urandom);
        for (int i = 0; i < NUM_REGS; i++)
            apb_read_check(IDX_W'(i));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen = {est_x, est_y, est_heading};
                if (estimates_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result expected none got %h %h %h",
                             $time, est_x, est_y, est_heading);
                end
                else
                begin
                    want = estimates_due.pop_front();
                    for (int f = 0; f < NUM_CH; f++)
                        if (seen[(NUM_CH-1-f)*DATA_W +: DATA_W]
                            !== want[(NUM_CH-1-f)*DATA_W +: DATA_W])
                        begin
                            mismatches++;
                            $display("%0t: %s expected %h got %h", $time, field_name[f],
                                     want[(NUM_CH-1-f)*DATA_W +: DATA_W],
                                     seen[(NUM_CH-1-f)*DATA_W +: DATA_W]);
                        end
                end
                stall_left = quiet ? 0 : $urandom_range(0, 5);
            end
            else if (stall_left > 0)
                stall_left--;
            out_ready <= (stall_left == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("three_axis_kalman_filter_core regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        kind = KIND_INIT;
        val_x = '0;
        val_y = '0;
        val_heading = '0;
        out_ready = 1'b0;
        cfg_regs[REG_PROC_NOISE_POS] = PROC_NOISE_POS_RST;
        cfg_regs[REG_PROC_NOISE_HEAD] = PROC_NOISE_HEAD_RST;
        cfg_regs[REG_MEAS_NOISE_POS] = MEAS_NOISE_POS_RST;
        cfg_regs[REG_MEAS_NOISE_HEAD] = MEAS_NOISE_HEAD_RST;
        cfg_regs[REG_INIT_VAR_POS] = INIT_VAR_POS_RST;
        cfg_regs[REG_INIT_VAR_HEAD] = INIT_VAR_HEAD_RST;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            est_q[ch] = 0;
            pest_q[ch] = 0;
            pvar_q[ch] = 0;
            var_q[ch] = (ch == CH_HEAD) ? INIT_VAR_HEAD_RST : INIT_VAR_POS_RST;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send(DIR_TBL[i].stim, DIR_TBL[i].known, DIR_TBL[i].want);
        run_random(PHASE_ITEMS);

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0: configure('0, '0, '0, '0, '0, '0);
                1: configure($urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0010_0000),
                             '0, '0, $urandom_range(1, 32'h0002_0000),
                             $urandom_range(1, 32'h0010_0000));
                2: configure('1, '1, '1, '1, '1, '1);
                3: configure('1, '1, '0, 32'h0000_0001, '0, '1);
                4, 6: configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                default: configure($urandom_range(0, 32'h0040_0000), $urandom_range(0, 32'h0040_0000),
                                   $urandom_range(0, 32'h0040_0000), $urandom_range(0, 32'h0040_0000),
                                   $urandom_range(0, 32'h0040_0000), $urandom_range(0, 32'h0040_0000));
            endcase
            run_random(PHASE_ITEMS);
        end

        while (estimates_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("three_axis_kalman_filter_core regression: pass");
        else
            $display("three_axis_kalman_filter_core regression: fail");
        $finish;
    end

endmodule

@@ three_axis_kalman_filter_core.f @@
src/tkf_pkg.sv
src/three_axis_kalman_filter_core.sv
bench/three_axis_kalman_filter_core_test.sv
